FILE: rtl/core/gble_pkg.sv
package gble_pkg;

	// Capacity of the character memory and the widths that follow from it.
	localparam int DEPTH = 4096;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMPW  = (CW > 13) ? CW : 13;
	localparam int WW    = CMPW + 1;

	localparam int MODE_W  = 3;
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 12;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 13;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BOUNDARY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_BEYOND   = 2'd3;

	typedef struct packed {
		logic [CHAR_W-1:0]  char_out;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] text_length;
		logic [COUNT_W-1:0] cursor_pos;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [AW-1:0]     waddr;
		logic [CHAR_W-1:0] wdata;
		logic [AW-1:0]     raddr;
	} mem_req_t;

	// Counts are reported through a fixed 13-bit field: extend or keep the low bits.
	function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
		logic [CMPW-1:0] t;
		t = CMPW'(c);
		return t[COUNT_W-1:0];
	endfunction

endpackage

FILE: rtl/core/gble_chan_if.sv
interface gble_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [gble_pkg::MODE_W-1:0]   mode;
	logic [gble_pkg::CHAR_W-1:0]   char_in;
	logic [gble_pkg::POS_W-1:0]    read_pos;

	modport source (output valid, output mode, output char_in, output read_pos, input ready);
	modport sink (input valid, input mode, input char_in, input read_pos, output ready);
endinterface

interface gble_res_if;
	logic                          valid;
	logic                          ready;
	logic [gble_pkg::CHAR_W-1:0]   char_out;
	logic [gble_pkg::STAT_W-1:0]   status;
	logic [gble_pkg::COUNT_W-1:0]  text_length;
	logic [gble_pkg::COUNT_W-1:0]  cursor_pos;

	modport source (output valid, output char_out, output status, output text_length,
		output cursor_pos, input ready);
	modport sink (input valid, input char_out, input status, input text_length,
		input cursor_pos, output ready);
endinterface

FILE: rtl/core/gble_ram.sv
module gble_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/gble_ctrl.sv
module gble_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	gble_cmd_if.sink                      cmd,
	input  logic                          slot_free,
	output logic                          res_valid,
	output gble_pkg::res_t                res_data,
	output gble_pkg::mem_req_t            mem_req,
	input  logic [gble_pkg::CHAR_W-1:0]   mem_rdata
);

	typedef enum logic {S_IDLE, S_MEM} state_t;

	state_t                        state_q, state_d;
	logic [gble_pkg::MODE_W-1:0]   mode_q;
	logic [gble_pkg::CW-1:0]       left_q, right_q, left_d, right_d;
	logic [gble_pkg::CW-1:0]       len, len_d;
	logic                          accept;
	logic [gble_pkg::WW-1:0]       pos_w, len_w, right_addr;
	logic [gble_pkg::CW-1:0]       top_addr;

	assign len   = left_q + right_q;
	assign len_d = left_d + right_d;
	assign pos_w = gble_pkg::WW'(cmd.read_pos);
	assign len_w = gble_pkg::WW'(len);
	// Text position to memory address for characters right of the cursor.
	assign right_addr = gble_pkg::WW'(gble_pkg::DEPTH) - gble_pkg::WW'(right_q)
		+ pos_w - gble_pkg::WW'(left_q);
	assign top_addr = gble_pkg::CW'(gble_pkg::DEPTH) - right_q;

	always_comb begin
		cmd.ready = (state_q == S_IDLE) && slot_free;
		accept    = cmd.valid && cmd.ready;
		state_d   = state_q;
		left_d    = left_q;
		right_d   = right_q;
		mem_req.we    = 1'b0;
		mem_req.waddr = left_q[gble_pkg::AW-1:0];
		mem_req.wdata = cmd.char_in;
		mem_req.raddr = left_q[gble_pkg::AW-1:0];
		res_valid         = 1'b0;
		res_data.char_out = '0;
		res_data.status   = gble_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_valid = 1'b1;
					case (cmd.mode)
						gble_pkg::MODE_INSERT: begin
							if (len == gble_pkg::CW'(gble_pkg::DEPTH)) begin
								res_data.status = gble_pkg::ST_FULL;
							end else begin
								mem_req.we = 1'b1;
								left_d     = left_q + 1'b1;
							end
						end
						gble_pkg::MODE_LEFT: begin
							if (left_q == '0) begin
								res_data.status = gble_pkg::ST_BOUNDARY;
							end else begin
								mem_req.raddr = left_d[gble_pkg::AW-1:0] - 1'b1;
								res_valid     = 1'b0;
								state_d       = S_MEM;
							end
						end
						gble_pkg::MODE_RIGHT: begin
							if (right_q == '0) begin
								res_data.status = gble_pkg::ST_BOUNDARY;
							end else begin
								mem_req.raddr = top_addr[gble_pkg::AW-1:0];
								res_valid     = 1'b0;
								state_d       = S_MEM;
							end
						end
						gble_pkg::MODE_BACK: begin
							if (left_q == '0) begin
								res_data.status = gble_pkg::ST_BOUNDARY;
							end else begin
								left_d = left_q - 1'b1;
							end
						end
						gble_pkg::MODE_READ: begin
							if (pos_w >= len_w) begin
								res_data.status = gble_pkg::ST_BEYOND;
							end else begin
								if (pos_w < gble_pkg::WW'(left_q)) begin
									mem_req.raddr = pos_w[gble_pkg::AW-1:0];
								end else begin
									mem_req.raddr = right_addr[gble_pkg::AW-1:0];
								end
								res_valid = 1'b0;
								state_d   = S_MEM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_MEM: begin
				// The slot was free when the command was taken and nothing has filled it since.
				res_valid     = 1'b1;
				state_d       = S_IDLE;
				mem_req.wdata = mem_rdata;
				case (mode_q)
					gble_pkg::MODE_LEFT: begin
						mem_req.we    = 1'b1;
						mem_req.waddr = top_addr[gble_pkg::AW-1:0] - 1'b1;
						left_d        = left_q - 1'b1;
						right_d       = right_q + 1'b1;
					end
					gble_pkg::MODE_RIGHT: begin
						mem_req.we = 1'b1;
						left_d     = left_q + 1'b1;
						right_d    = right_q - 1'b1;
					end
					default: begin
						res_data.char_out = mem_rdata;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res_data.text_length = gble_pkg::to_count(len_d);
		res_data.cursor_pos  = gble_pkg::to_count(left_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q  <= '0;
			right_q <= '0;
			mode_q  <= gble_pkg::MODE_INSERT;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			right_q <= right_d;
			if (accept) begin
				mode_q <= cmd.mode;
			end
		end
	end

endmodule

FILE: rtl/core/gap_buffer_line_editor.sv
// Line editor that keeps its text as a gap buffer in one synchronous character memory of
// gble_pkg::DEPTH entries: text left of the cursor fills the bottom of the memory, text right of
// it the top. Each command transfer yields exactly one result transfer. Insert, backspace, any
// command refused at a boundary or beyond the text, and unused mode codes end in the cycle they
// are accepted; cursor moves and reads inside the text also pass through S_MEM to read the
// memory's registered port (a move then writes the data across the gap). A new command is taken
// once the previous one has finished and the result register is empty or being drained in the
// same cycle. Memory is not cleared at reset; only characters of the current text are ever read.
module gap_buffer_line_editor (
	input  logic       clk,
	input  logic       arst_n,
	gble_cmd_if.sink   cmd,
	gble_res_if.source res
);

	logic                          slot_free;
	logic                          res_valid;
	gble_pkg::res_t                res_data;
	gble_pkg::mem_req_t            mem_req;
	logic [gble_pkg::CHAR_W-1:0]   mem_rdata;
	logic                          out_valid_q;
	gble_pkg::res_t                out_data_q;

	assign slot_free = !out_valid_q || res.ready;

	gble_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res_data  (res_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	gble_ram #(
		.DEPTH (gble_pkg::DEPTH),
		.AW    (gble_pkg::AW),
		.DW    (gble_pkg::CHAR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.char_out    = out_data_q.char_out;
	assign res.status      = out_data_q.status;
	assign res.text_length = out_data_q.text_length;
	assign res.cursor_pos  = out_data_q.cursor_pos;

endmodule
